[hdl/jbt_pkg.sv]
// ============================================================================
// jbt_pkg
// Shared types, token and error codes, and keyword tables for the JSON byte
// tokenizer.
// ============================================================================
package jbt_pkg;

    localparam int POSITION_BITS = 32;
    localparam int LINE_BITS     = 32;
    localparam int FIELD_BITS    = 32;
    localparam int MAX_RESULTS   = 3;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = FIFO_AW + 1;

    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [LINE_BITS-1:0]     t_line;
    typedef logic [3:0]               t_kind;
    typedef logic [2:0]               t_err;
    typedef logic [RES_CNT_W-1:0]     t_res_cnt;

    localparam t_kind K_END    = 4'd0;
    localparam t_kind K_LBRACE = 4'd1;
    localparam t_kind K_RBRACE = 4'd2;
    localparam t_kind K_LBRACK = 4'd3;
    localparam t_kind K_RBRACK = 4'd4;
    localparam t_kind K_COLON  = 4'd5;
    localparam t_kind K_COMMA  = 4'd6;
    localparam t_kind K_STRING = 4'd7;
    localparam t_kind K_BOOL   = 4'd8;
    localparam t_kind K_NULL   = 4'd9;
    localparam t_kind K_NUMBER = 4'd10;
    localparam t_kind K_ERROR  = 4'd11;

    localparam t_err E_NONE    = 3'd0;
    localparam t_err E_ESCAPE  = 3'd1;
    localparam t_err E_CTRL    = 3'd2;
    localparam t_err E_UNTERM  = 3'd3;
    localparam t_err E_INVALID = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_input;
    } t_item;

    typedef struct packed {
        t_kind                 token_kind;
        logic [FIELD_BITS-1:0] token_start;
        logic [FIELD_BITS-1:0] token_length;
        logic [FIELD_BITS-1:0] line_number;
        logic                  bool_value;
        t_err                  error_kind;
        logic                  last_in_run;
    } t_result;

    typedef struct packed {
        t_res_cnt                      count;
        t_result [MAX_RESULTS-1:0]     res;
    } t_push;

    function automatic t_result make_result(t_kind kind, t_pos start, t_pos len,
                                            t_line line, logic bv, t_err err);
        t_result r;
        r.token_kind   = kind;
        r.token_start  = FIELD_BITS'(start);
        r.token_length = FIELD_BITS'(len);
        r.line_number  = FIELD_BITS'(line);
        r.bool_value   = bv;
        r.error_kind   = err;
        r.last_in_run  = 1'b0;
        return r;
    endfunction

    // keyword 0 true, 1 false, 2 null
    function automatic logic [2:0] kw_len(logic [1:0] k);
        logic [2:0] l;
        unique case (k)
            2'd1:    l = 3'd5;
            default: l = 3'd4;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (k)
            2'd0: begin
                unique case (idx)
                    3'd0:    c = 8'h74;
                    3'd1:    c = 8'h72;
                    3'd2:    c = 8'h75;
                    3'd3:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            2'd1: begin
                unique case (idx)
                    3'd0:    c = 8'h66;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h73;
                    3'd4:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (idx)
                    3'd0:    c = 8'h6E;
                    3'd1:    c = 8'h75;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h6C;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hdl/jbt_lexer.sv]
// ============================================================================
// jbt_lexer
// Input register and single-pass lexer: takes one registered byte per cycle
// when the queue has room, updates scan state and queues up to three tokens.
// ============================================================================
module jbt_lexer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  jbt_pkg::t_item i_in_item,
    input  logic           i_space,
    output jbt_pkg::t_push o_push
);
    import jbt_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_STR  = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_HEX  = 3'd3;
    localparam logic [2:0] PH_NUM  = 3'd4;
    localparam logic [2:0] PH_KW0  = 3'd5;
    localparam logic [2:0] PH_KW1  = 3'd6;
    localparam logic [2:0] PH_KW2  = 3'd7;

    localparam logic [3:0] N_START = 4'd0;
    localparam logic [3:0] N_MINUS = 4'd1;
    localparam logic [3:0] N_ZERO  = 4'd2;
    localparam logic [3:0] N_INT   = 4'd3;
    localparam logic [3:0] N_DOT   = 4'd4;
    localparam logic [3:0] N_FRAC  = 4'd5;
    localparam logic [3:0] N_E     = 4'd6;
    localparam logic [3:0] N_ESIGN = 4'd7;
    localparam logic [3:0] N_EXP   = 4'd8;
    localparam logic [3:0] N_DEAD  = 4'd9;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic logic is_digit(logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic [3:0] num_next(logic [3:0] s, logic [7:0] b);
        logic       d;
        logic       e;
        logic [3:0] ns;
        d = is_digit(b);
        e = (b == CH_E) || (b == CH_UE);
        unique case (s)
            N_START: ns = (b == CH_MINUS) ? N_MINUS : (b == CH_0) ? N_ZERO :
                          d ? N_INT : N_DEAD;
            N_MINUS: ns = (b == CH_0) ? N_ZERO : d ? N_INT : N_DEAD;
            N_ZERO:  ns = (b == CH_DOT) ? N_DOT : e ? N_E : N_DEAD;
            N_INT:   ns = d ? N_INT : (b == CH_DOT) ? N_DOT : e ? N_E : N_DEAD;
            N_DOT:   ns = d ? N_FRAC : N_DEAD;
            N_FRAC:  ns = d ? N_FRAC : e ? N_E : N_DEAD;
            N_E:     ns = ((b == CH_PLUS) || (b == CH_MINUS)) ? N_ESIGN :
                          d ? N_EXP : N_DEAD;
            N_ESIGN: ns = d ? N_EXP : N_DEAD;
            N_EXP:   ns = d ? N_EXP : N_DEAD;
            default: ns = N_DEAD;
        endcase
        return ns;
    endfunction

    function automatic logic num_ok(logic [3:0] s);
        return (s == N_ZERO) || (s == N_INT) || (s == N_FRAC) || (s == N_EXP);
    endfunction

    logic       r_in_v;
    t_item      r_in;
    logic [2:0] r_phase, n_phase;
    t_pos       r_pos, n_pos;
    t_line      r_line, n_line;
    t_pos       r_tb, n_tb;
    logic [2:0] r_kw, n_kw;
    logic [3:0] r_nd, n_nd;
    logic [2:0] r_es, n_es;
    logic       r_err, n_err;

    logic                      fire;
    logic                      do_idle;
    logic [1:0]                kw_sel;
    logic [7:0]                b;
    t_res_cnt                  cnt;
    t_result [MAX_RESULTS-1:0] res;

    assign fire       = r_in_v && i_space;
    assign o_in_ready = !r_in_v || i_space;
    assign b          = r_in.data_byte;
    assign kw_sel     = 2'(r_phase - PH_KW0);

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_line  = r_line;
        n_tb    = r_tb;
        n_kw    = r_kw;
        n_nd    = r_nd;
        n_es    = r_es;
        n_err   = r_err;
        cnt     = '0;
        res     = '0;
        do_idle = 1'b0;

        if (r_in.has_byte && !r_err) begin
            unique case (r_phase) inside
                PH_STR: begin
                    if (b == CH_QUOTE) begin
                        res[cnt] = make_result(K_STRING, r_tb, r_pos - r_tb, n_line,
                                               1'b0, E_NONE);
                        cnt     = cnt + 1'b1;
                        n_phase = PH_IDLE;
                    end else if (b == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else if (b < CH_SPACE) begin
                        res[cnt] = make_result(K_ERROR, r_pos, '0, n_line, 1'b0, E_CTRL);
                        cnt     = cnt + 1'b1;
                        n_err   = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                PH_ESC: begin
                    if (b == CH_U) begin
                        n_phase = PH_HEX;
                        n_es    = 3'd4;
                    end else if (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH ||
                                 b == CH_B || b == CH_F || b == CH_N || b == CH_R ||
                                 b == CH_T) begin
                        n_phase = PH_STR;
                    end else begin
                        res[cnt] = make_result(K_ERROR, r_pos, '0, n_line, 1'b0, E_ESCAPE);
                        cnt     = cnt + 1'b1;
                        n_err   = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                PH_HEX: begin
                    if (r_es != 3'd0) begin
                        n_es = r_es - 3'd1;
                    end
                    if (n_es == 3'd0) begin
                        n_phase = PH_STR;
                    end
                end
                PH_KW0, PH_KW1, PH_KW2: begin
                    if (r_kw >= kw_len(kw_sel) || b != kw_char(kw_sel, r_kw)) begin
                        res[cnt] = make_result(K_ERROR, r_pos, '0, n_line, 1'b0, E_INVALID);
                        cnt     = cnt + 1'b1;
                        n_err   = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_kw = r_kw + 3'd1;
                        if (n_kw == kw_len(kw_sel)) begin
                            if (kw_sel == 2'd2) begin
                                res[cnt] = make_result(K_NULL, r_tb, POSITION_BITS'(4),
                                                       n_line, 1'b0, E_NONE);
                            end else begin
                                res[cnt] = make_result(K_BOOL, r_tb,
                                                       POSITION_BITS'(kw_len(kw_sel)),
                                                       n_line, kw_sel == 2'd0, E_NONE);
                            end
                            cnt     = cnt + 1'b1;
                            n_phase = PH_IDLE;
                            n_kw    = 3'd0;
                        end
                    end
                end
                PH_NUM: begin
                    if (b == CH_COMMA || b == CH_RBRACK || b == CH_RBRACE ||
                        b == CH_COLON || b == CH_SPACE || b == CH_TAB ||
                        b == CH_LF || b == CH_CR) begin
                        n_phase = PH_IDLE;
                        if (num_ok(r_nd)) begin
                            res[cnt] = make_result(K_NUMBER, r_tb, r_pos - r_tb, n_line,
                                                   1'b0, E_NONE);
                            cnt     = cnt + 1'b1;
                            do_idle = 1'b1;
                        end else begin
                            res[cnt] = make_result(K_ERROR, r_pos, '0, n_line, 1'b0,
                                                   E_INVALID);
                            cnt   = cnt + 1'b1;
                            n_err = 1'b1;
                        end
                    end else begin
                        n_nd = num_next(r_nd, b);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle) begin
                case (b) inside
                    CH_LF: begin
                        if (n_line != '1) begin
                            n_line = n_line + 1'b1;
                        end
                    end
                    CH_SPACE, CH_TAB, CH_CR: begin
                    end
                    CH_LBRACE: begin
                        res[cnt] = make_result(K_LBRACE, r_pos, POSITION_BITS'(1), n_line,
                                               1'b0, E_NONE);
                        cnt = cnt + 1'b1;
                    end
                    CH_RBRACE: begin
                        res[cnt] = make_result(K_RBRACE, r_pos, POSITION_BITS'(1), n_line,
                                               1'b0, E_NONE);
                        cnt = cnt + 1'b1;
                    end
                    CH_LBRACK: begin
                        res[cnt] = make_result(K_LBRACK, r_pos, POSITION_BITS'(1), n_line,
                                               1'b0, E_NONE);
                        cnt = cnt + 1'b1;
                    end
                    CH_RBRACK: begin
                        res[cnt] = make_result(K_RBRACK, r_pos, POSITION_BITS'(1), n_line,
                                               1'b0, E_NONE);
                        cnt = cnt + 1'b1;
                    end
                    CH_COLON: begin
                        res[cnt] = make_result(K_COLON, r_pos, POSITION_BITS'(1), n_line,
                                               1'b0, E_NONE);
                        cnt = cnt + 1'b1;
                    end
                    CH_COMMA: begin
                        res[cnt] = make_result(K_COMMA, r_pos, POSITION_BITS'(1), n_line,
                                               1'b0, E_NONE);
                        cnt = cnt + 1'b1;
                    end
                    CH_QUOTE: begin
                        n_phase = PH_STR;
                        n_tb    = r_pos + 1'b1;
                    end
                    CH_T, CH_F, CH_N: begin
                        n_phase = (b == CH_T) ? PH_KW0 : (b == CH_F) ? PH_KW1 : PH_KW2;
                        n_tb    = r_pos;
                        n_kw    = 3'd1;
                    end
                    [CH_0:CH_9], CH_MINUS: begin
                        n_phase = PH_NUM;
                        n_tb    = r_pos;
                        n_nd    = num_next(N_START, b);
                    end
                    default: begin
                        res[cnt] = make_result(K_ERROR, r_pos, '0, n_line, 1'b0, E_INVALID);
                        cnt     = cnt + 1'b1;
                        n_err   = 1'b1;
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            n_pos = r_pos + 1'b1;
        end

        if (r_in.end_of_input) begin
            if (!n_err) begin
                unique case (n_phase) inside
                    PH_STR, PH_ESC, PH_HEX: begin
                        res[cnt] = make_result(K_ERROR, n_pos, '0, n_line, 1'b0, E_UNTERM);
                        cnt = cnt + 1'b1;
                    end
                    PH_KW0, PH_KW1, PH_KW2: begin
                        res[cnt] = make_result(K_ERROR, n_pos, '0, n_line, 1'b0, E_INVALID);
                        cnt = cnt + 1'b1;
                    end
                    PH_NUM: begin
                        if (num_ok(n_nd)) begin
                            res[cnt] = make_result(K_NUMBER, n_tb, n_pos - n_tb, n_line,
                                                   1'b0, E_NONE);
                            cnt = cnt + 1'b1;
                            res[cnt] = make_result(K_END, n_pos, '0, n_line, 1'b0, E_NONE);
                            cnt = cnt + 1'b1;
                        end else begin
                            res[cnt] = make_result(K_ERROR, n_pos, '0, n_line, 1'b0,
                                                   E_INVALID);
                            cnt = cnt + 1'b1;
                        end
                    end
                    default: begin
                        res[cnt] = make_result(K_END, n_pos, '0, n_line, 1'b0, E_NONE);
                        cnt = cnt + 1'b1;
                    end
                endcase
            end
            // new stream
            n_phase = PH_IDLE;
            n_pos   = '0;
            n_line  = LINE_BITS'(1);
            n_tb    = '0;
            n_kw    = 3'd0;
            n_nd    = N_START;
            n_es    = 3'd0;
            n_err   = 1'b0;
        end

        if (cnt != '0) begin
            res[cnt - 1'b1].last_in_run = 1'b1;
        end
    end

    assign o_push = '{count: (fire ? cnt : t_res_cnt'(0)), res: res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_line  <= LINE_BITS'(1);
            r_tb    <= '0;
            r_kw    <= 3'd0;
            r_nd    <= N_START;
            r_es    <= 3'd0;
            r_err   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_v <= i_in_valid;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_line  <= n_line;
                r_tb    <= n_tb;
                r_kw    <= n_kw;
                r_nd    <= n_nd;
                r_es    <= n_es;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

`ifndef SYNTHESIS
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count != '0 |-> o_push.res[o_push.count - 1'b1].last_in_run)
        else $error("last pushed token lacks last_in_run");

    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err && !(fire && r_in.end_of_input) |=> r_err)
        else $error("latched error cleared before end of input");

    a_eoi_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.end_of_input |=> r_phase == PH_IDLE && r_pos == '0 && !r_err)
        else $error("scan state not reset after end of input");
`endif

endmodule

[hdl/jbt_result_fifo.sv]
// ============================================================================
// jbt_result_fifo
// Small result queue: takes up to three tokens per cycle from the lexer and
// delivers one per output transaction.
// ============================================================================
module jbt_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jbt_pkg::t_push   i_push,
    output logic             o_space,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output jbt_pkg::t_result o_out_result
);
    import jbt_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr, n_wr;
    logic [FIFO_AW-1:0]    r_rd, n_rd;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  pop;

    assign o_space      = r_count <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS);
    assign o_out_valid  = r_count != '0;
    assign o_out_result = r_mem[r_rd];
    assign pop          = o_out_valid && i_out_ready;

    assign n_wr    = r_wr + FIFO_AW'(i_push.count);
    assign n_rd    = r_rd + FIFO_AW'(pop);
    assign n_count = r_count + FIFO_CNT_W'(i_push.count) - FIFO_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (RES_CNT_W'(i) < i_push.count) begin
                r_mem[r_wr + FIFO_AW'(i)] <= i_push.res[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count != '0 |->
            (r_count + FIFO_CNT_W'(i_push.count)) <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_with_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count != '0 |-> o_space)
        else $error("tokens pushed while the result queue is short of room");
`endif

endmodule

[hdl/json_byte_tokenizer_unit.sv]
// path: each input is registered, then its tokens are queued before the output
// throughput: one byte per cycle while the output is ready and each byte yields
//   at most one token; the output gives one token per cycle, so bytes yielding
//   two or three tokens fill the 8-entry result queue and back-pressure input
// reset: synchronous active low; scan state returns to the stream start and
//   the result queue empties
// ============================================================================
// json_byte_tokenizer_unit
// JSON byte tokenizer: registered single-pass lexer feeding a result queue.
// ============================================================================
module json_byte_tokenizer_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  jbt_pkg::t_item   i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output jbt_pkg::t_result o_out_result
);
    import jbt_pkg::*;

    t_push push;
    logic  space;

    jbt_lexer u_lexer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_space    (space),
        .o_push     (push)
    );

    jbt_result_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_space      (space),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_result (o_out_result)
    );

endmodule

[sim/testbench.sv]
// ============================================================================
// testbench
// Checks the JSON byte tokenizer against a token predictor kept in step
// with every accepted input transaction. Short directed streams come first,
// then random streams that are mostly well-formed JSON with some noise,
// broken tokens and cut-off text. Both sides idle at random, and the output
// side holds off once for a long stretch to back up the result queue.
// ============================================================================
module testbench;
    import jbt_pkg::*;

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_STRING, SCAN_ESCAPE, SCAN_HEX, SCAN_NUMBER,
        SCAN_TRUE, SCAN_FALSE, SCAN_NULL
    } t_scan;

    typedef enum logic [3:0] {
        NUM_START, NUM_MINUS, NUM_ZERO, NUM_INT, NUM_DOT, NUM_FRAC,
        NUM_EXP_MARK, NUM_EXP_SIGN, NUM_EXP_DIGITS, NUM_DEAD
    } t_num;

    localparam int PHASE_ITEMS = 135;
    localparam int LONG_STALL  = 150;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    logic    o_in_ready;
    t_item   i_in_item = '0;
    logic    o_out_valid;
    logic    i_out_ready = 1'b0;
    t_result o_out_result;

    json_byte_tokenizer_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_result (o_out_result)
    );

    t_item       stim_items[$];
    t_result     expected_tokens[$];
    t_result     step_tokens[$];
    logic [7:0]  json_text[$];
    string       kw_words[3] = '{"true", "false", "null"};

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  stall_requests = 0;
    int  stall_served = 0;
    int  stall_left = 0;
    int  failures = 0;
    int  phase_items = 0;
    bit  in_fired = 1'b0;

    // predictor state
    t_scan       scan_phase;
    t_pos        scan_pos;
    t_line       scan_line;
    t_pos        tok_begin;
    logic [2:0]  kw_idx;
    t_num        num_state;
    logic [2:0]  hex_left;
    bit          err_seen;

    function automatic void clear_scan();
        scan_phase = SCAN_IDLE;
        scan_pos   = '0;
        scan_line  = 1;
        tok_begin  = '0;
        kw_idx     = '0;
        num_state  = NUM_START;
        hex_left   = '0;
        err_seen   = 1'b0;
    endfunction

    function automatic void add_token(t_kind kind, t_pos start, t_pos len, logic bv, t_err err);
        t_result r;
        r.token_kind   = kind;
        r.token_start  = start;
        r.token_length = len;
        r.line_number  = scan_line;
        r.bool_value   = bv;
        r.error_kind   = err;
        r.last_in_run  = 1'b0;
        if (step_tokens.size() < MAX_RESULTS)
            step_tokens.push_back(r);
    endfunction

    function automatic void flag_error(t_err err, t_pos at);
        add_token(K_ERROR, at, '0, 1'b0, err);
        err_seen   = 1'b1;
        scan_phase = SCAN_IDLE;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic t_num num_step(t_num s, logic [7:0] b);
        bit d;
        bit e;
        d = is_digit(b);
        e = (b == "e") || (b == "E");
        case (s)
            NUM_START:      return b == "-" ? NUM_MINUS : b == "0" ? NUM_ZERO :
                                   d ? NUM_INT : NUM_DEAD;
            NUM_MINUS:      return b == "0" ? NUM_ZERO : d ? NUM_INT : NUM_DEAD;
            NUM_ZERO:       return b == "." ? NUM_DOT : e ? NUM_EXP_MARK : NUM_DEAD;
            NUM_INT:        return d ? NUM_INT : b == "." ? NUM_DOT :
                                   e ? NUM_EXP_MARK : NUM_DEAD;
            NUM_DOT:        return d ? NUM_FRAC : NUM_DEAD;
            NUM_FRAC:       return d ? NUM_FRAC : e ? NUM_EXP_MARK : NUM_DEAD;
            NUM_EXP_MARK:   return (b == "+" || b == "-") ? NUM_EXP_SIGN :
                                   d ? NUM_EXP_DIGITS : NUM_DEAD;
            NUM_EXP_SIGN:   return d ? NUM_EXP_DIGITS : NUM_DEAD;
            NUM_EXP_DIGITS: return d ? NUM_EXP_DIGITS : NUM_DEAD;
            default:        return NUM_DEAD;
        endcase
    endfunction

    function automatic bit close_number();
        scan_phase = SCAN_IDLE;
        if (num_state == NUM_ZERO || num_state == NUM_INT ||
            num_state == NUM_FRAC || num_state == NUM_EXP_DIGITS) begin
            add_token(K_NUMBER, tok_begin, scan_pos - tok_begin, 1'b0, E_NONE);
            return 1'b1;
        end
        flag_error(E_INVALID, scan_pos);
        return 1'b0;
    endfunction

    function automatic void scan_between(logic [7:0] b);
        t_pos p;
        p = scan_pos;
        case (b)
            8'h0A: begin
                if (scan_line != '1)
                    scan_line = scan_line + 1;
            end
            8'h20, 8'h09, 8'h0D: ;
            "{": add_token(K_LBRACE, p, 1, 1'b0, E_NONE);
            "}": add_token(K_RBRACE, p, 1, 1'b0, E_NONE);
            "[": add_token(K_LBRACK, p, 1, 1'b0, E_NONE);
            "]": add_token(K_RBRACK, p, 1, 1'b0, E_NONE);
            ":": add_token(K_COLON, p, 1, 1'b0, E_NONE);
            ",": add_token(K_COMMA, p, 1, 1'b0, E_NONE);
            "\"": begin
                scan_phase = SCAN_STRING;
                tok_begin  = p + 1;
            end
            "t", "f", "n": begin
                scan_phase = b == "t" ? SCAN_TRUE : b == "f" ? SCAN_FALSE : SCAN_NULL;
                tok_begin  = p;
                kw_idx     = 3'd1;
            end
            default: begin
                if (is_digit(b) || b == "-") begin
                    scan_phase = SCAN_NUMBER;
                    tok_begin  = p;
                    num_state  = num_step(NUM_START, b);
                end else begin
                    flag_error(E_INVALID, p);
                end
            end
        endcase
    endfunction

    function automatic void scan_byte(logic [7:0] b);
        t_pos p;
        int   k;
        p = scan_pos;
        case (scan_phase)
            SCAN_STRING: begin
                if (b == "\"") begin
                    add_token(K_STRING, tok_begin, p - tok_begin, 1'b0, E_NONE);
                    scan_phase = SCAN_IDLE;
                end else if (b == "\\") begin
                    scan_phase = SCAN_ESCAPE;
                end else if (b < 8'h20) begin
                    flag_error(E_CTRL, p);
                end
            end
            SCAN_ESCAPE: begin
                if (b == "u") begin
                    scan_phase = SCAN_HEX;
                    hex_left   = 3'd4;
                end else if (b == "\"" || b == "\\" || b == "/" || b == "b" ||
                             b == "f" || b == "n" || b == "r" || b == "t") begin
                    scan_phase = SCAN_STRING;
                end else begin
                    flag_error(E_ESCAPE, p);
                end
            end
            SCAN_HEX: begin
                if (hex_left > 0)
                    hex_left = hex_left - 3'd1;
                if (hex_left == 0)
                    scan_phase = SCAN_STRING;
            end
            SCAN_TRUE, SCAN_FALSE, SCAN_NULL: begin
                k = scan_phase == SCAN_TRUE ? 0 : scan_phase == SCAN_FALSE ? 1 : 2;
                if (kw_idx >= kw_words[k].len() || b != kw_words[k][kw_idx]) begin
                    flag_error(E_INVALID, p);
                end else begin
                    kw_idx = kw_idx + 3'd1;
                    if (kw_idx == kw_words[k].len()) begin
                        if (k == 2)
                            add_token(K_NULL, tok_begin, 4, 1'b0, E_NONE);
                        else
                            add_token(K_BOOL, tok_begin, kw_words[k].len(), k == 0, E_NONE);
                        scan_phase = SCAN_IDLE;
                        kw_idx     = 3'd0;
                    end
                end
            end
            SCAN_NUMBER: begin
                if (b == "," || b == "]" || b == "}" || b == ":" ||
                    b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D) begin
                    if (close_number())
                        scan_between(b);
                end else begin
                    num_state = num_step(num_state, b);
                end
            end
            default: begin
                scan_phase = SCAN_IDLE;
                scan_between(b);
            end
        endcase
    endfunction

    function automatic void predict_tokens(t_item it);
        t_result r;
        if (it.has_byte && !err_seen) begin
            scan_byte(it.data_byte);
            scan_pos = scan_pos + 1;
        end
        if (it.end_of_input) begin
            if (!err_seen) begin
                case (scan_phase)
                    SCAN_STRING, SCAN_ESCAPE, SCAN_HEX: flag_error(E_UNTERM, scan_pos);
                    SCAN_TRUE, SCAN_FALSE, SCAN_NULL:   flag_error(E_INVALID, scan_pos);
                    SCAN_NUMBER: begin
                        if (close_number())
                            add_token(K_END, scan_pos, '0, 1'b0, E_NONE);
                    end
                    default: add_token(K_END, scan_pos, '0, 1'b0, E_NONE);
                endcase
            end
            clear_scan();
        end
        if (step_tokens.size() > 0) begin
            r = step_tokens.pop_back();
            r.last_in_run = 1'b1;
            step_tokens.push_back(r);
        end
        while (step_tokens.size() > 0)
            expected_tokens.push_back(step_tokens.pop_front());
    endfunction

    // stream builders
    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            json_text.push_back(s[i]);
    endfunction

    function automatic void put_space();
        int n;
        n = $urandom_range(2);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(4))
                0:       json_text.push_back(8'h09);
                1:       json_text.push_back(8'h0D);
                2, 3:    json_text.push_back(8'h0A);
                default: json_text.push_back(8'h20);
            endcase
        end
    endfunction

    function automatic void put_string();
        string      escapes;
        logic [7:0] c;
        int         n;
        int         r;
        escapes = "\"\\/bfnrt";
        json_text.push_back("\"");
        n = $urandom_range(5);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 60) begin
                c = 8'($urandom_range(8'h7E, 8'h20));
                json_text.push_back((c == "\"" || c == "\\") ? 8'h61 : c);
            end else if (r < 75) begin
                json_text.push_back(8'($urandom_range(8'hFF, 8'h80)));
            end else if (r < 88) begin
                json_text.push_back("\\");
                json_text.push_back(escapes[$urandom_range(escapes.len() - 1)]);
            end else if (r < 96) begin
                put_str("\\u");
                for (int j = 0; j < 4; j++)
                    json_text.push_back(8'($urandom_range(255)));
            end else if (r < 98) begin
                json_text.push_back("\\");
                json_text.push_back($urandom_range(1) ? "x" : "U");
            end else begin
                json_text.push_back(8'($urandom_range(8'h1F, 8'h00)));
            end
        end
        json_text.push_back("\"");
    endfunction

    function automatic void put_number();
        string broken[8] = '{"01", "1.", "-", "1e", "1e+", "-.5", "2.x", "0e"};
        int    n;
        if ($urandom_range(9) == 0) begin
            put_str(broken[$urandom_range(7)]);
            return;
        end
        if ($urandom_range(2) == 0)
            json_text.push_back("-");
        if ($urandom_range(3) == 0) begin
            json_text.push_back("0");
        end else begin
            json_text.push_back(8'($urandom_range("9", "1")));
            n = $urandom_range(3);
            for (int i = 0; i < n; i++)
                json_text.push_back(8'($urandom_range("9", "0")));
        end
        if ($urandom_range(2) == 0) begin
            json_text.push_back(".");
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++)
                json_text.push_back(8'($urandom_range("9", "0")));
        end
        if ($urandom_range(3) == 0) begin
            json_text.push_back($urandom_range(1) ? "e" : "E");
            case ($urandom_range(2))
                0:       json_text.push_back("+");
                1:       json_text.push_back("-");
                default: ;
            endcase
            n = $urandom_range(2, 1);
            for (int i = 0; i < n; i++)
                json_text.push_back(8'($urandom_range("9", "0")));
        end
    endfunction

    function automatic void put_keyword();
        string w;
        int    cut;
        w = kw_words[$urandom_range(2)];
        case ($urandom_range(11))
            0: begin
                cut = $urandom_range(w.len() - 1, 1);
                w[cut] = 8'($urandom_range("z", "a"));
                put_str(w);
            end
            1: put_str(w.substr(0, $urandom_range(w.len() - 2)));
            default: put_str(w);
        endcase
    endfunction

    function automatic void put_value(int depth);
        int pick;
        int n;
        pick = depth >= 2 ? $urandom_range(4, 2) : $urandom_range(4);
        case (pick)
            0: begin
                json_text.push_back("{");
                put_space();
                n = $urandom_range(3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0)
                        json_text.push_back(",");
                    put_space();
                    put_string();
                    put_space();
                    json_text.push_back(":");
                    put_space();
                    put_value(depth + 1);
                    put_space();
                end
                json_text.push_back("}");
            end
            1: begin
                json_text.push_back("[");
                n = $urandom_range(3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0)
                        json_text.push_back(",");
                    put_space();
                    put_value(depth + 1);
                    put_space();
                end
                json_text.push_back("]");
            end
            2: put_string();
            3: put_number();
            default: put_keyword();
        endcase
    endfunction

    function automatic void queue_text(bit end_on_last);
        t_item it;
        while (json_text.size() > 0) begin
            if ($urandom_range(39) == 0) begin
                it.data_byte    = 8'($urandom_range(255));
                it.has_byte     = 1'b0;
                it.end_of_input = 1'b0;
                stim_items.push_back(it);
            end
            it.data_byte    = json_text.pop_front();
            it.has_byte     = 1'b1;
            it.end_of_input = end_on_last && json_text.size() == 0;
            stim_items.push_back(it);
            phase_items++;
        end
        if (!end_on_last || it.end_of_input !== 1'b1) begin
            it.data_byte    = 8'($urandom_range(255));
            it.has_byte     = 1'b0;
            it.end_of_input = 1'b1;
            stim_items.push_back(it);
            phase_items++;
        end
    endfunction

    function automatic void queue_random_stream();
        int r;
        int n;
        r = $urandom_range(99);
        json_text.delete();
        if (r < 8) begin
            n = $urandom_range(6);
            for (int i = 0; i < n; i++)
                json_text.push_back(8'($urandom_range(255)));
        end else begin
            put_space();
            put_value(0);
            if ($urandom_range(4) == 0) begin
                json_text.push_back(8'h0A);
                put_value(0);
            end
            put_space();
            if (r < 16) begin
                n = $urandom_range(json_text.size() - 1);
                while (json_text.size() > n)
                    void'(json_text.pop_back());
            end
        end
        queue_text($urandom_range(1));
    endfunction

    function automatic void check_token(t_result exp, t_result got);
        if (got.token_kind !== exp.token_kind) begin
            $error("token_kind expected %0d actual %0d", exp.token_kind, got.token_kind);
            failures++;
        end
        if (got.token_start !== exp.token_start) begin
            $error("token_start expected %0d actual %0d", exp.token_start, got.token_start);
            failures++;
        end
        if (got.token_length !== exp.token_length) begin
            $error("token_length expected %0d actual %0d", exp.token_length,
                   got.token_length);
            failures++;
        end
        if (got.line_number !== exp.line_number) begin
            $error("line_number expected %0d actual %0d", exp.line_number, got.line_number);
            failures++;
        end
        if (got.bool_value !== exp.bool_value) begin
            $error("bool_value expected %0d actual %0d", exp.bool_value, got.bool_value);
            failures++;
        end
        if (got.error_kind !== exp.error_kind) begin
            $error("error_kind expected %0d actual %0d", exp.error_kind, got.error_kind);
            failures++;
        end
        if (got.last_in_run !== exp.last_in_run) begin
            $error("last_in_run expected %0d actual %0d", exp.last_in_run, got.last_in_run);
            failures++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // sampling: predict on input transactions, check on output transactions
    always @(posedge i_clk) begin
        in_fired = i_rst_n && i_in_valid && o_in_ready;
        if (in_fired)
            predict_tokens(i_in_item);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected token: kind %0d start %0d", o_out_result.token_kind,
                       o_out_result.token_start);
                failures++;
            end else begin
                check_token(expected_tokens.pop_front(), o_out_result);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fired)) begin
            if (stim_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_item  <= stim_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (stall_served < stall_requests) begin
            stall_served++;
            stall_left = LONG_STALL;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    initial begin
        #6000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int send_pcts[3];
        int recv_pcts[3];
        send_pcts = '{21, 88, 0};
        recv_pcts = '{88, 21, 0};
        clear_scan();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = $urandom_range(1) ? 0 : 30;
        recv_idle_pct = $urandom_range(1) ? 0 : 30;
        put_str("{[]:,}");
        queue_text(1'b1);
        put_str("-0.5e+3]");
        queue_text(1'b1);
        put_str("\"\\u");
        queue_text(1'b0);
        json_text.push_back(8'hFF);
        put_str("x");
        queue_text(1'b0);
        put_str("true");
        queue_text(1'b1);
        while (stim_items.size() != 0 || i_in_valid)
            @(posedge i_clk);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = send_pcts[ph];
            recv_idle_pct = recv_pcts[ph];
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                queue_random_stream();
            // hold the output off while the input keeps streaming
            if (ph == 2)
                stall_requests++;
            while (stim_items.size() != 0 || i_in_valid)
                @(posedge i_clk);
        end

        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
